### rtl/gpio_prb_pkg.sv
// Shared types, register map codes and pin helpers for the GPIO port register block.
package gpio_prb_pkg;

   // Access kinds
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Word register map
   localparam logic [3:0] REG_MODE  = 4'd0;
   localparam logic [3:0] REG_OTYPE = 4'd1;
   localparam logic [3:0] REG_SPEED = 4'd2;
   localparam logic [3:0] REG_PULL  = 4'd3;
   localparam logic [3:0] REG_IDR   = 4'd4;
   localparam logic [3:0] REG_ODR   = 4'd5;
   localparam logic [3:0] REG_BSRR  = 4'd6;
   localparam logic [3:0] REG_LOCK  = 4'd7;
   localparam logic [3:0] REG_AFL   = 4'd8;
   localparam logic [3:0] REG_AFH   = 4'd9;

   // Lock key sequence steps
   localparam logic [1:0] LOCK_WAIT_FIRST  = 2'd0;
   localparam logic [1:0] LOCK_WAIT_SECOND = 2'd1;
   localparam logic [1:0] LOCK_WAIT_THIRD  = 2'd2;

   localparam int unsigned LockKeyBit = 16;

   typedef struct packed {
      logic        operation;
      logic [3:0]  register_index;
      logic [31:0] write_data;
      logic [15:0] pin_levels;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [15:0] pin_out;
      logic [15:0] output_enable;
      logic        lock_active;
   } rsp_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_HOLD
   } state_type;

   // Command from controller to datapath
   typedef struct packed {
      logic execute;
      logic hold_result;
   } cmd_type;

   // Widen a pin mask to the 2-bit-per-pin fields
   function automatic logic [31:0] spread2(input logic [15:0] pins);
      logic [31:0] r;
      r = '0;
      for (int i = 0; i < 16; i++) begin
         r[2*i +: 2] = {2{pins[i]}};
      end
      return r;
   endfunction

   // Widen an 8-pin mask to the 4-bit-per-pin fields
   function automatic logic [31:0] spread4(input logic [7:0] pins);
      logic [31:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         r[4*i +: 4] = {4{pins[i]}};
      end
      return r;
   endfunction

endpackage

### rtl/gpio_prb_ctrl.sv
// Handshake controller for the GPIO port register block.
module gpio_prb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output gpio_prb_pkg::cmd_type cmd
);
   import gpio_prb_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      req_ready       = 1'b0;
      rsp_valid       = 1'b0;
      cmd.execute     = 1'b0;
      cmd.hold_result = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.execute = req_valid;
            if (req_valid) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            rsp_valid       = 1'b1;
            req_ready       = rsp_ready;
            cmd.execute     = req_valid && rsp_ready;
            cmd.hold_result = !rsp_ready;
            if (rsp_ready && !req_valid) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/gpio_prb_dp.sv
// Register file, lock logic and response register of the GPIO port.
module gpio_prb_dp #(
   parameter int unsigned PIN_COUNT = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gpio_prb_pkg::cmd_type cmd,
   input  gpio_prb_pkg::req_type req,
   output gpio_prb_pkg::rsp_type rsp
);
   import gpio_prb_pkg::*;

   localparam logic [15:0] PinMask =
      (PIN_COUNT >= 16) ? 16'hFFFF : 16'((32'd1 << PIN_COUNT) - 32'd1);

   logic [31:0] mode_ff,  mode_in;
   logic [15:0] otype_ff, otype_in;
   logic [31:0] speed_ff, speed_in;
   logic [31:0] pull_ff,  pull_in;
   logic [15:0] odr_ff,   odr_in;
   logic [31:0] afl_ff,   afl_in;
   logic [31:0] afh_ff,   afh_in;
   logic [16:0] lock_ff,  lock_in;
   logic [1:0]  step_ff,  step_in;
   rsp_type     rsp_ff,   rsp_in;

   logic [15:0] writable;
   logic [15:0] sample;
   logic [15:0] lock_pins;
   logic        key;
   logic        same;
   logic        locked;
   logic        is_write;
   logic [31:0] rd;
   logic [15:0] oe;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= '0;
         otype_ff <= '0;
         speed_ff <= '0;
         pull_ff  <= '0;
         odr_ff   <= '0;
         afl_ff   <= '0;
         afh_ff   <= '0;
         lock_ff  <= '0;
         step_ff  <= LOCK_WAIT_FIRST;
      end else begin
         mode_ff  <= mode_in;
         otype_ff <= otype_in;
         speed_ff <= speed_in;
         pull_ff  <= pull_in;
         odr_ff   <= odr_in;
         afl_ff   <= afl_in;
         afh_ff   <= afh_in;
         lock_ff  <= lock_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign locked    = lock_ff[LockKeyBit];
   assign writable  = PinMask & ~(locked ? lock_ff[15:0] : 16'h0000);
   assign sample    = req.pin_levels & PinMask;
   assign lock_pins = req.write_data[15:0] & PinMask;
   assign key       = req.write_data[LockKeyBit];
   assign same      = (lock_pins == lock_ff[15:0]);
   assign is_write  = cmd.execute && (req.operation == OP_WRITE);

   // Register updates
   always_comb begin
      mode_in  = mode_ff;
      otype_in = otype_ff;
      speed_in = speed_ff;
      pull_in  = pull_ff;
      odr_in   = odr_ff;
      afl_in   = afl_ff;
      afh_in   = afh_ff;
      lock_in  = lock_ff;
      step_in  = step_ff;
      if (is_write) begin
         unique case (req.register_index)
            REG_MODE: begin
               mode_in = (mode_ff & ~spread2(writable)) | (req.write_data & spread2(writable));
            end
            REG_OTYPE: begin
               otype_in = (otype_ff & ~writable) | (req.write_data[15:0] & writable);
            end
            REG_SPEED: begin
               speed_in = (speed_ff & ~spread2(writable)) | (req.write_data & spread2(writable));
            end
            REG_PULL: begin
               pull_in = (pull_ff & ~spread2(writable)) | (req.write_data & spread2(writable));
            end
            REG_ODR: begin
               odr_in = req.write_data[15:0] & PinMask;
            end
            REG_BSRR: begin
               // set wins over reset
               odr_in = ((odr_ff & ~req.write_data[31:16]) | req.write_data[15:0]) & PinMask;
            end
            REG_LOCK: begin
               if (!locked) begin
                  priority if (step_ff == LOCK_WAIT_SECOND && !key && same) begin
                     step_in = LOCK_WAIT_THIRD;
                     lock_in = {1'b0, lock_pins};
                  end else if (step_ff == LOCK_WAIT_THIRD && key && same) begin
                     step_in = LOCK_WAIT_FIRST;
                     lock_in = {1'b1, lock_pins};
                  end else begin
                     // restart the key sequence
                     step_in = key ? LOCK_WAIT_SECOND : LOCK_WAIT_FIRST;
                     lock_in = {1'b0, lock_pins};
                  end
               end
            end
            REG_AFL: begin
               afl_in = (afl_ff & ~spread4(writable[7:0]))
                        | (req.write_data & spread4(writable[7:0]));
            end
            REG_AFH: begin
               afh_in = (afh_ff & ~spread4(writable[15:8]))
                        | (req.write_data & spread4(writable[15:8]));
            end
            default: begin
            end
         endcase
      end
   end

   // Read mux
   always_comb begin
      rd = '0;
      if (req.operation == OP_READ) begin
         unique case (req.register_index)
            REG_MODE:  rd = mode_ff;
            REG_OTYPE: rd = {16'h0000, otype_ff};
            REG_SPEED: rd = speed_ff;
            REG_PULL:  rd = pull_ff;
            REG_IDR:   rd = {16'h0000, sample};
            REG_ODR:   rd = {16'h0000, odr_ff};
            REG_LOCK:  rd = {15'h0000, lock_ff};
            REG_AFL:   rd = afl_ff;
            REG_AFH:   rd = afh_ff;
            default:   rd = '0;
         endcase
      end
   end

   // Output mode (01) or alternate function (10) drives the pin
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         oe[i] = mode_in[2*i] ^ mode_in[2*i+1];
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.execute) begin
         rsp_in.read_data     = rd;
         rsp_in.pin_out       = odr_in;
         rsp_in.output_enable = oe & PinMask;
         rsp_in.lock_active   = lock_in[LockKeyBit];
      end else if (!cmd.hold_result) begin
         rsp_in = rsp_ff;
      end
   end

   assign rsp = rsp_ff;

endmodule

### rtl/gpio_prb_top.sv
// Top level of the GPIO port register block.
// Latency: a request's response is valid in the cycle after it is accepted.
// Throughput: one request per cycle; a new request is taken in the same cycle
// the held response is consumed, set by the single response register.
// Reset: synchronous, active high; all port registers, the lock mask and the
// lock key step clear to zero and the response channel empties.
module gpio_port_register_block_top #(
   parameter int unsigned PIN_COUNT = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  gpio_prb_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output gpio_prb_pkg::rsp_type rsp_payload
);
   import gpio_prb_pkg::*;

   cmd_type cmd;

   // Controller: hold the response until taken, advance on each accepted request
   gpio_prb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Datapath: register file, lock sequence and response register
   gpio_prb_dp #(
      .PIN_COUNT (PIN_COUNT)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .req   (req_payload),
      .rsp   (rsp_payload)
   );

endmodule

### tb/testbench.sv
// Self-checking testbench for the GPIO port register block: random and directed bus accesses.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import gpio_prb_pkg::*;

   localparam int unsigned RandomPerPhase = 430;
   localparam int unsigned LongHoldCycles = 200;
   localparam int unsigned CycleLimit     = 300000;
   localparam int unsigned DrainCycles    = 4;

   // Clock, reset and the block's ports; every input starts at a known value
   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   // Requests waiting to be offered, and port states awaited from the block
   req_type pending_requests[$];
   rsp_type awaited_port_states[$];

   // Idling percentages per phase and the long receiver hold-off
   int unsigned send_idle_pct = 7;
   int unsigned recv_idle_pct = 77;
   logic        hold_kick     = 1'b0;
   int unsigned hold_left;

   int unsigned cycle_count   = 0;
   int unsigned mismatches    = 0;
   int unsigned checked_count = 0;
   int unsigned queued_count  = 0;

   // Predicted port state, updated in request order
   logic [31:0] port_mode;
   logic [15:0] port_otype;
   logic [31:0] port_speed;
   logic [31:0] port_pull;
   logic [15:0] port_odr;
   logic [15:0] port_idr;
   logic [31:0] port_afl;
   logic [31:0] port_afh;
   logic [16:0] port_lock;
   logic [1:0]  key_step;

   gpio_port_register_block_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Print one line per mismatch and count it
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at response %0d: %s got %h, expected %h",
               checked_count, what, got, want);
      mismatches++;
   endtask

   // Apply one request to the predicted port and return the outputs it shows afterwards
   function automatic rsp_type predict_port_access(input req_type rq);
      rsp_type     rs;
      logic        locked;
      logic        key;
      logic [15:0] open_pins;
      logic [15:0] key_pins;
      logic [31:0] pair_mask;
      logic [31:0] nibble_lo;
      logic [31:0] nibble_hi;
      locked    = port_lock[16];
      open_pins = locked ? ~port_lock[15:0] : 16'hFFFF;
      for (int b = 0; b < 32; b++) begin
         pair_mask[b] = open_pins[b / 2];
         nibble_lo[b] = open_pins[b / 4];
         nibble_hi[b] = open_pins[8 + b / 4];
      end
      // The pins are sampled on every request, read or write
      port_idr = rq.pin_levels;
      rs       = '0;
      if (rq.operation == OP_WRITE) begin
         case (rq.register_index)
            REG_MODE:  port_mode  = (port_mode & ~pair_mask) | (rq.write_data & pair_mask);
            REG_OTYPE: port_otype = (port_otype & ~open_pins)
                                    | (rq.write_data[15:0] & open_pins);
            REG_SPEED: port_speed = (port_speed & ~pair_mask) | (rq.write_data & pair_mask);
            REG_PULL:  port_pull  = (port_pull & ~pair_mask) | (rq.write_data & pair_mask);
            REG_ODR:   port_odr   = rq.write_data[15:0];
            // Clear first, then set, so that set wins
            REG_BSRR:  port_odr   = (port_odr & ~rq.write_data[31:16]) | rq.write_data[15:0];
            REG_LOCK: begin
               if (!locked) begin
                  key      = rq.write_data[LockKeyBit];
                  key_pins = rq.write_data[15:0];
                  if (key_step == LOCK_WAIT_SECOND && !key && key_pins == port_lock[15:0]) begin
                     key_step  = LOCK_WAIT_THIRD;
                     port_lock = {1'b0, key_pins};
                  end else if (key_step == LOCK_WAIT_THIRD && key
                               && key_pins == port_lock[15:0]) begin
                     key_step  = LOCK_WAIT_FIRST;
                     port_lock = {1'b1, key_pins};
                  end else begin
                     // A step out of order restarts the key sequence
                     key_step  = key ? LOCK_WAIT_SECOND : LOCK_WAIT_FIRST;
                     port_lock = {1'b0, key_pins};
                  end
               end
            end
            REG_AFL:   port_afl   = (port_afl & ~nibble_lo) | (rq.write_data & nibble_lo);
            REG_AFH:   port_afh   = (port_afh & ~nibble_hi) | (rq.write_data & nibble_hi);
            default: ;
         endcase
      end else begin
         case (rq.register_index)
            REG_MODE:  rs.read_data = port_mode;
            REG_OTYPE: rs.read_data = {16'h0, port_otype};
            REG_SPEED: rs.read_data = port_speed;
            REG_PULL:  rs.read_data = port_pull;
            REG_IDR:   rs.read_data = {16'h0, port_idr};
            REG_ODR:   rs.read_data = {16'h0, port_odr};
            REG_LOCK:  rs.read_data = {15'h0, port_lock};
            REG_AFL:   rs.read_data = port_afl;
            REG_AFH:   rs.read_data = port_afh;
            default:   rs.read_data = '0;
         endcase
      end
      // A pin drives when its mode is output or alternate function
      for (int p = 0; p < 16; p++) begin
         rs.output_enable[p] = port_mode[2*p+1] ^ port_mode[2*p];
      end
      rs.pin_out     = port_odr;
      rs.lock_active = port_lock[16];
      return rs;
   endfunction

   task automatic queue_access(input logic op, input logic [3:0] idx,
                               input logic [31:0] data, input logic [15:0] pins);
      req_type rq;
      rq.operation      = op;
      rq.register_index = idx;
      rq.write_data     = data;
      rq.pin_levels     = pins;
      pending_requests.push_back(rq);
      queued_count++;
   endtask

   // Queue the three lock key writes with reads scattered between them; unless the
   // sequence is to complete, spoil one step by its key or its pin mask
   task automatic queue_lock_attempt(input bit complete);
      logic [15:0] mask;
      logic [15:0] step_mask;
      logic        key;
      int unsigned spoilt;
      mask   = 16'($urandom);
      spoilt = complete ? 3 : $urandom_range(0, 2);
      for (int s = 0; s < 3; s++) begin
         repeat ($urandom_range(0, 2)) begin
            queue_access(OP_READ, 4'($urandom_range(0, 15)), $urandom, 16'($urandom));
         end
         key       = (s != 1);
         step_mask = mask;
         if (s == spoilt) begin
            if ($urandom_range(0, 1) == 1) key = ~key;
            else step_mask = mask ^ (16'h1 << $urandom_range(0, 15));
         end
         queue_access(OP_WRITE, REG_LOCK, {15'($urandom), key, step_mask}, 16'($urandom));
      end
   endtask

   // Reset state of the predictor
   initial begin
      port_mode  = '0;
      port_otype = '0;
      port_speed = '0;
      port_pull  = '0;
      port_odr   = '0;
      port_idr   = '0;
      port_afl   = '0;
      port_afh   = '0;
      port_lock  = '0;
      key_step   = LOCK_WAIT_FIRST;
   end

   // Driver: offer the next pending request and predict each one accepted.
   // Hold valid and the payload until the request is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_port_states.push_back(predict_port_access(req_payload));
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_payload <= pending_requests.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here so the block fills and stalls its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_kick) begin
         hold_left <= LongHoldCycles;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: drive ready and check each accepted response against the oldest prediction
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
         if (rsp_valid && rsp_ready) begin
            if (awaited_port_states.size() == 0) begin
               report_mismatch("response with nothing awaited, read_data",
                               rsp_payload.read_data, '0);
            end else begin
               want = awaited_port_states.pop_front();
               if (rsp_payload.read_data !== want.read_data)
                  report_mismatch("read_data", rsp_payload.read_data, want.read_data);
               if (rsp_payload.pin_out !== want.pin_out)
                  report_mismatch("pin_out", {16'h0, rsp_payload.pin_out}, {16'h0, want.pin_out});
               if (rsp_payload.output_enable !== want.output_enable)
                  report_mismatch("output_enable", {16'h0, rsp_payload.output_enable},
                                  {16'h0, want.output_enable});
               if (rsp_payload.lock_active !== want.lock_active)
                  report_mismatch("lock_active", {31'h0, rsp_payload.lock_active},
                                  {31'h0, want.lock_active});
            end
            checked_count++;
         end
      end
   end

   // Watchdog: drop the run if it overruns
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Stimulus: reset, a directed sweep, then three random phases with different idling
   initial begin : stimulus
      logic [3:0] idx;
      logic [31:0] data;
      bit          lock_done;
      int unsigned phase_target;
      lock_done = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct <= 7;
               recv_idle_pct <= 77;
            end
            1: begin
               send_idle_pct <= 77;
               recv_idle_pct <= 7;
            end
            default: begin
               send_idle_pct <= 0;
               recv_idle_pct <= 0;
            end
         endcase

         if (phase == 0) begin
            // Register extremes, the set/reset priority and the read-only registers
            queue_access(OP_READ,  REG_MODE,  32'hFFFF_FFFF, 16'h0000);
            queue_access(OP_WRITE, REG_MODE,  32'hFFFF_FFFF, 16'hFFFF);
            queue_access(OP_WRITE, REG_MODE,  32'h5555_AAAA, 16'h0000);
            queue_access(OP_READ,  REG_MODE,  32'h0000_0000, 16'hFFFF);
            queue_access(OP_WRITE, REG_OTYPE, 32'hFFFF_FFFF, 16'($urandom));
            queue_access(OP_WRITE, REG_SPEED, 32'hFFFF_FFFF, 16'($urandom));
            queue_access(OP_WRITE, REG_PULL,  32'hA5A5_5A5A, 16'($urandom));
            queue_access(OP_WRITE, REG_AFL,   32'hFFFF_FFFF, 16'($urandom));
            queue_access(OP_WRITE, REG_AFH,   32'h1234_5678, 16'($urandom));
            queue_access(OP_WRITE, REG_IDR,   32'hFFFF_FFFF, 16'h0000);
            queue_access(OP_READ,  REG_IDR,   32'h0000_0000, 16'hFFFF);
            queue_access(OP_WRITE, REG_ODR,   32'hFFFF_FFFF, 16'($urandom));
            queue_access(OP_WRITE, REG_BSRR,  32'hFFFF_0000, 16'($urandom));
            queue_access(OP_WRITE, REG_BSRR,  32'hFFFF_FFFF, 16'($urandom));
            queue_access(OP_READ,  REG_BSRR,  32'hFFFF_FFFF, 16'($urandom));
            // Unmapped words
            queue_access(OP_WRITE, 4'd15,     32'hFFFF_FFFF, 16'($urandom));
            queue_access(OP_READ,  4'd10,     32'h0000_0000, 16'($urandom));
            // Broken key sequences: repeated first step, wrong mask, wrong key
            queue_access(OP_WRITE, REG_LOCK,  32'h0001_00F0, 16'($urandom));
            queue_access(OP_WRITE, REG_LOCK,  32'h0001_00F0, 16'($urandom));
            queue_access(OP_WRITE, REG_LOCK,  32'h0000_00F0, 16'($urandom));
            queue_access(OP_WRITE, REG_LOCK,  32'h0001_0F00, 16'($urandom));
            queue_access(OP_WRITE, REG_LOCK,  32'h0000_0F00, 16'($urandom));
            queue_access(OP_WRITE, REG_LOCK,  32'h0000_0F00, 16'($urandom));
            queue_access(OP_WRITE, REG_LOCK,  32'hFFFE_FFFF, 16'($urandom));
            queue_access(OP_READ,  REG_LOCK,  32'h0000_0000, 16'($urandom));
         end

         // Random accesses, with key sequences mixed in; the lock completes only once,
         // part way through the last phase, so the frozen pins get exercised after it
         phase_target = queued_count + RandomPerPhase;
         while (queued_count < phase_target) begin
            if ($urandom_range(0, 24) == 0) begin
               queue_lock_attempt(phase == 2 && !lock_done
                                  && queued_count + RandomPerPhase / 2 > phase_target);
               if (phase == 2 && queued_count + RandomPerPhase / 2 > phase_target)
                  lock_done = 1'b1;
            end else begin
               if ($urandom_range(0, 7) == 0) idx = 4'($urandom_range(10, 15));
               else idx = 4'($urandom_range(0, 9));
               case ($urandom_range(0, 7))
                  0:       data = '0;
                  1:       data = '1;
                  default: data = $urandom;
               endcase
               queue_access(logic'($urandom_range(0, 1)), idx, data, 16'($urandom));
            end
         end

         // With the sender never idle, hold the receiver off so the block backs up
         if (phase == 2) begin
            @(posedge clock);
            hold_kick <= 1'b1;
            @(posedge clock);
            hold_kick <= 1'b0;
         end

         while (pending_requests.size() != 0 || req_valid) @(posedge clock);
      end

      // Wait for a response to every queued request, then let the bench drain to catch strays
      while (checked_count < queued_count) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
